// ----- hdl/lfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Line follower steering package
// Shared types and constants for the line follower steering block.
// ----------------------------------------------------------------------------
package lfs_pkg;

  typedef struct packed {
    logic [7:0] line_sensors;
    logic       sat_right;
    logic       sat_left;
  } sample_t;

  typedef struct packed {
    logic [7:0] steer_position;
    logic       steer_updated;
    logic       edge_right_led;
  } steer_t;

  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_RIGHT = 2'd1,
    EDGE_LEFT  = 2'd2
  } edge_t;

  typedef enum logic {
    CFG_PROPORTIONAL_GAIN = 1'b0,
    CFG_DERIVATIVE_GAIN   = 1'b1
  } cfg_index_t;

  localparam int FRAC_BITS = 12;
  localparam logic [19:0] POS_MAX_Q   = 20'(243 << FRAC_BITS);
  localparam logic [19:0] POS_MIN_Q   = 20'(14 << FRAC_BITS);
  localparam logic [19:0] POS_START_Q = 20'(135 << FRAC_BITS);

  localparam logic signed [15:0] PROPORTIONAL_GAIN_RESET = 16'sd532;
  localparam logic signed [15:0] DERIVATIVE_GAIN_RESET   = 16'sd82;

  localparam logic [7:0] LOW_NIBBLE_FULL = 8'h0F;
  localparam logic [7:0] FILL_LEFT       = 8'h80;
  localparam logic [7:0] FILL_RIGHT      = 8'h01;

  localparam logic signed [5:0] ERR_CORNER_RIGHT = -6'sd15;
  localparam logic signed [5:0] ERR_CORNER_LEFT  = 6'sd19;
  localparam logic signed [5:0] ERR_ONE          = 6'sd1;
  localparam logic signed [5:0] ERR_MINUS_ONE    = -6'sd1;

  localparam logic [3:0] ERR_TABLE [16] = '{
    4'd0, 4'd8, 4'd5, 4'd6, 4'd3, 4'd0, 4'd4, 4'd0,
    4'd1, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd0, 4'd0
  };

endpackage

// ----- hdl/line_follower_steering.sv -----
// ----------------------------------------------------------------------------
// Line follower steering
// Branch and corner detection, edge selection and PD steer position update.
// ----------------------------------------------------------------------------
// Each transfer on the sample channel carries one line-sensor reading and the
// two outer auxiliary sensor bits. Each reading yields exactly one transfer on
// the steer channel with the clamped servo position, a flag that tells whether
// the PD update ran, and the right-edge indicator.
// The sample is captured in an input register; from there all pattern logic,
// the two gain multiplies, the accumulate and the clamp run in one pass into
// the result register. Steer valid is registered beside the result, so a
// steer transfer follows the input and result registers in turn, and one
// sample is taken every cycle while the receiver does not stall.
// The rate is set by the single pass through the multiply, add and clamp that
// closes the loop on the steer position.
// When the receiver stalls, the result register holds, the input register
// holds one more sample, and then sample_stall rises.
// Synchronous reset empties both registers, restores the gains to their
// defaults, selects the right edge and sets the start position to 135.
// Gain writes on the configuration port take effect on the next sample.
// ----------------------------------------------------------------------------
module line_follower_steering (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [0:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            sample_valid,
  output logic            sample_stall,
  input  lfs_pkg::sample_t sample,
  output logic            steer_valid,
  input  logic            steer_stall,
  output lfs_pkg::steer_t steer
);
  import lfs_pkg::*;

  logic signed [15:0] proportional_gain;
  logic signed [15:0] derivative_gain;
  edge_t              followed_edge;
  edge_t              pending_edge;
  logic               branch_phase;
  logic               center_seen;
  logic [7:0]         last_nonzero_sample;
  logic signed [5:0]  held_error;
  logic signed [5:0]  previous_error;
  logic [19:0]        position_accum;
  logic               led_level;

  logic               in_valid;
  sample_t            in_q;
  logic               advance;

  edge_t              followed_edge_next;
  edge_t              pending_edge_next;
  logic               branch_phase_next;
  logic               center_seen_next;
  logic [7:0]         last_nonzero_sample_next;
  logic signed [5:0]  held_error_next;
  logic signed [5:0]  previous_error_next;
  logic [19:0]        position_accum_next;
  logic               led_level_next;
  logic               skip;

  logic [7:0]         s;
  logic [7:0]         s_fill;
  logic               sr;
  logic               sl;
  logic               br;
  logic               fill_path;
  logic [3:0]         rev_nib;
  logic signed [6:0]  err_diff;
  logic signed [21:0] p_term;
  logic signed [22:0] d_term;
  logic               sign_flip;
  logic signed [25:0] accum_sum;

  function automatic logic two_frag(input logic [7:0] v, input int lo, input int hi,
                                    input logic r, input logic l);
    logic [1:0] st;
    st = 2'd0;
    for (int i = 0; i < 8; i++) begin
      if (i >= lo && i <= hi) begin
        if (i == 0 && r) st = 2'd1;
        if (st == 2'd0) begin
          if (v[i]) st = 2'd1;
        end else if (st == 2'd1) begin
          if (!v[i]) st = 2'd2;
        end else if (st == 2'd2) begin
          if (v[i]) st = 2'd3;
        end
        if (i == 7 && l && st == 2'd2) st = 2'd3;
      end
    end
    return st == 2'd3;
  endfunction

  function automatic logic corner_match(input logic [4:0] a);
    return a == 5'd7 || a == 5'd14 || a == 5'd28 || a == 5'd15 || a == 5'd30 || a == 5'd31;
  endfunction

  function automatic logic few_black(input logic [6:0] v);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int i = 0; i < 7; i++) begin
      cnt = cnt + {2'b0, v[i]};
    end
    return cnt <= 3'd2;
  endfunction

  assign advance      = !steer_valid || !steer_stall;
  assign sample_stall = in_valid && !advance;

  assign s  = in_q.line_sensors;
  assign sr = in_q.sat_right;
  assign sl = in_q.sat_left;
  assign br = two_frag(s, 0, 7, sr, sl);

  always_comb begin
    followed_edge_next  = followed_edge;
    pending_edge_next   = pending_edge;
    branch_phase_next   = branch_phase;
    center_seen_next    = center_seen;
    led_level_next      = led_level;
    held_error_next     = held_error;
    skip                = 1'b0;
    fill_path           = 1'b0;

    if (!branch_phase) begin
      if (br) branch_phase_next = 1'b1;
    end else if (!br && !(s[3] && s[4]) && few_black(s[6:0])) begin
      followed_edge_next = pending_edge;
      led_level_next     = (pending_edge == EDGE_RIGHT);
      center_seen_next   = 1'b1;
      branch_phase_next  = 1'b0;
    end

    unique case (followed_edge_next)
      EDGE_RIGHT: begin
        if (s[3] && !s[2]) begin
          center_seen_next = 1'b0;
          if (br) pending_edge_next = two_frag(s, 3, 7, sr, sl) ? EDGE_LEFT : EDGE_RIGHT;
          skip = 1'b1;
        end else if (!s[3] && s[2]) begin
          held_error_next  = ERR_MINUS_ONE;
          center_seen_next = 1'b1;
        end else if (!s[3] && !s[2]) begin
          if (br) begin
            if (center_seen_next) begin
              pending_edge_next = two_frag(s, 0, 2, sr, sl) ? EDGE_RIGHT : EDGE_LEFT;
            end else begin
              pending_edge_next = two_frag(s, 3, 7, sr, sl) ? EDGE_LEFT : EDGE_RIGHT;
            end
          end
          fill_path = 1'b1;
        end else begin
          held_error_next  = corner_match({s[3:0], sr}) ? ERR_CORNER_RIGHT : ERR_MINUS_ONE;
          center_seen_next = 1'b1;
          if (br) pending_edge_next = two_frag(s, 3, 7, sr, sl) ? EDGE_LEFT : EDGE_RIGHT;
        end
      end
      EDGE_LEFT: begin
        if (!s[5] && s[4]) begin
          center_seen_next = 1'b0;
          if (br) pending_edge_next = two_frag(s, 0, 4, sr, sl) ? EDGE_RIGHT : EDGE_LEFT;
          skip = 1'b1;
        end else if (s[5] && !s[4]) begin
          held_error_next  = ERR_ONE;
          center_seen_next = 1'b1;
        end else if (!s[5] && !s[4]) begin
          if (center_seen_next) begin
            held_error_next = ERR_ONE;
            if (br) pending_edge_next = two_frag(s, 5, 7, sr, sl) ? EDGE_LEFT : EDGE_RIGHT;
          end else begin
            held_error_next = ERR_MINUS_ONE;
            if (br) pending_edge_next = two_frag(s, 0, 3, sr, sl) ? EDGE_RIGHT : EDGE_LEFT;
          end
          fill_path = 1'b1;
        end else begin
          held_error_next  = (!corner_match({s[3:0], sr}) && corner_match({sl, s[7:4]}))
                             ? ERR_CORNER_LEFT : ERR_ONE;
          center_seen_next = 1'b1;
          if (br) pending_edge_next = two_frag(s, 0, 4, sr, sl) ? EDGE_RIGHT : EDGE_LEFT;
        end
      end
      default: begin
      end
    endcase

    s_fill = s;
    if (fill_path && s == 8'd0) begin
      s_fill = (last_nonzero_sample > LOW_NIBBLE_FULL) ? FILL_LEFT : FILL_RIGHT;
    end
    rev_nib = {s_fill[4], s_fill[5], s_fill[6], s_fill[7]};
    if (fill_path && !two_frag(s_fill, 0, 7, sr, sl)) begin
      if (s_fill > LOW_NIBBLE_FULL) begin
        held_error_next = $signed({2'b00, ERR_TABLE[rev_nib]});
      end else if (s_fill < LOW_NIBBLE_FULL) begin
        held_error_next = $signed(6'd0 - {2'b00, ERR_TABLE[s_fill[3:0]]});
      end
    end

    last_nonzero_sample_next = (s_fill != 8'd0) ? s_fill : last_nonzero_sample;

    err_diff  = {held_error_next[5], held_error_next} - {previous_error[5], previous_error};
    p_term    = proportional_gain * held_error_next;
    sign_flip = (held_error_next > 6'sd0 && previous_error < 6'sd0) ||
                (held_error_next < 6'sd0 && previous_error > 6'sd0);
    d_term    = sign_flip ? 23'sd0 : derivative_gain * err_diff;
    accum_sum = $signed({6'b0, position_accum}) + {{4{p_term[21]}}, p_term}
                + {{3{d_term[22]}}, d_term};

    previous_error_next = previous_error;
    position_accum_next = position_accum;
    if (!skip) begin
      previous_error_next = held_error_next;
      if (accum_sum > $signed({6'b0, POS_MAX_Q})) begin
        position_accum_next = POS_MAX_Q;
      end else if (accum_sum < $signed({6'b0, POS_MIN_Q})) begin
        position_accum_next = POS_MIN_Q;
      end else begin
        position_accum_next = accum_sum[19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proportional_gain <= PROPORTIONAL_GAIN_RESET;
      derivative_gain   <= DERIVATIVE_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PROPORTIONAL_GAIN: proportional_gain <= $signed(cfg_data);
        CFG_DERIVATIVE_GAIN:   derivative_gain   <= $signed(cfg_data);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || advance) begin
      in_valid <= sample_valid;
    end
    if (!in_valid || advance) begin
      in_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      followed_edge       <= EDGE_RIGHT;
      pending_edge        <= EDGE_NONE;
      branch_phase        <= 1'b0;
      center_seen         <= 1'b0;
      last_nonzero_sample <= 8'd0;
      held_error          <= 6'sd0;
      previous_error      <= 6'sd0;
      position_accum      <= POS_START_Q;
      led_level           <= 1'b1;
    end else if (in_valid && advance) begin
      followed_edge       <= followed_edge_next;
      pending_edge        <= pending_edge_next;
      branch_phase        <= branch_phase_next;
      center_seen         <= center_seen_next;
      last_nonzero_sample <= last_nonzero_sample_next;
      held_error          <= held_error_next;
      previous_error      <= previous_error_next;
      position_accum      <= position_accum_next;
      led_level           <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_valid <= 1'b0;
    end else if (advance) begin
      steer_valid <= in_valid;
    end
    if (advance && in_valid) begin
      steer.steer_position <= position_accum_next[19:FRAC_BITS];
      steer.steer_updated  <= !skip;
      steer.edge_right_led <= led_level_next;
    end
  end

endmodule
